// File: rtl/core/bs_pkg.sv
// Shared constants, codes and types of the bitonic sorter.
package bs_pkg;

   localparam int MAX_KEYS   = 64;
   localparam int KEY_W      = 64;
   localparam int MAX_LOG2   = $clog2(MAX_KEYS + 1) - 1;
   localparam int ADDR_W     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int BANK_AW    = (ADDR_W > 1) ? ADDR_W - 1 : 1;
   localparam int BANK_DEPTH = (MAX_KEYS + 1) / 2;
   localparam int STAGE_W    = $clog2(MAX_LOG2 + 1);
   localparam int COUNT_W    = ADDR_W + 1;
   localparam int SIZE_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_SORT_ASCENDING = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_LOG2      = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 3'd6;

   // One compare-exchange issued by the network sequencer.
   typedef struct packed {
      logic              ce_valid;
      logic              done;
      logic              up;
      logic [ADDR_W-1:0] p;
      logic [ADDR_W-1:0] q;
   } seq_out_type;

endpackage

// File: rtl/core/bs_if.sv
// Item channel interfaces of the bitonic sorter.
interface bs_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [bs_pkg::KEY_W-1:0]  key_in;

   modport source (output valid, output key_in, input ready);
   modport sink   (input valid, input key_in, output ready);
endinterface

interface bs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [bs_pkg::KEY_W-1:0]  key_out;
   logic                             last_key;

   modport source (output valid, output key_out, output last_key, input ready);
   modport sink   (input valid, input key_out, input last_key, output ready);
endinterface

// File: rtl/core/bs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bs_seq.sv
// Schedule of the bitonic network: one compare-exchange pair per cycle, stage by stage, with a gap between stages.
module bs_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bs_pkg::STAGE_W-1:0]       l,
   input  logic                             asc,
   output bs_pkg::seq_out_type              seq_out
);

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_RUN, SEQ_GAP} seq_state_type;

   seq_state_type                state_ff, state_in;
   logic [bs_pkg::STAGE_W-1:0]   k_ff, k_in;
   logic [bs_pkg::STAGE_W-1:0]   j_ff, j_in;
   logic [bs_pkg::BANK_AW-1:0]   c_ff, c_in;

   logic [bs_pkg::COUNT_W-1:0]   n_half;
   logic [bs_pkg::BANK_AW-1:0]   half_last;
   logic [bs_pkg::ADDR_W-1:0]    cx;
   logic [bs_pkg::ADDR_W-1:0]    low_mask;
   logic [bs_pkg::ADDR_W-1:0]    p;
   logic [bs_pkg::ADDR_W:0]      p_sh;
   logic                         last_stage;

   always_comb begin
      n_half    = (bs_pkg::COUNT_W'(1) << l) >> 1;
      half_last = bs_pkg::BANK_AW'(n_half - bs_pkg::COUNT_W'(1));
      // The pair index is the counter with a zero slotted in at bit j.
      cx        = bs_pkg::ADDR_W'(c_ff);
      low_mask  = ~({bs_pkg::ADDR_W{1'b1}} << j_ff);
      p         = ((cx >> j_ff) << (j_ff + 1'b1)) | (cx & low_mask);
      p_sh      = {1'b0, p} >> k_ff;
      last_stage = (j_ff == '0) && (k_ff == l);

      seq_out.ce_valid = (state_ff == SEQ_RUN);
      seq_out.done     = (state_ff == SEQ_GAP) && last_stage;
      seq_out.p        = p;
      seq_out.q        = p | (bs_pkg::ADDR_W'(1) << j_ff);
      // Inner blocks alternate direction; the final merge takes the requested one.
      seq_out.up       = (k_ff == l) ? asc : ~p_sh[0];
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      c_in     = c_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               k_in     = bs_pkg::STAGE_W'(1);
               j_in     = '0;
               c_in     = '0;
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            if (c_ff == half_last) begin
               state_in = SEQ_GAP;
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         SEQ_GAP: begin
            // The gap cycle lets the last write of a stage land before the next reads.
            c_in = '0;
            if (j_ff == '0) begin
               if (k_ff == l) begin
                  state_in = SEQ_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  j_in     = k_ff;
                  state_in = SEQ_RUN;
               end
            end else begin
               j_in     = j_ff - 1'b1;
               state_in = SEQ_RUN;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         k_ff     <= '0;
         j_ff     <= '0;
         c_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
         c_ff     <= c_in;
      end
   end

endmodule

// File: rtl/core/bitonic_sorter_core.sv
// Bitonic sorter top level: key store in two RAM banks, sort sequencing and result output.
//
//  Channel   Direction  Contents
//  req_chan  in         key_in, one key per item
//  rsp_chan  out        key_out and last_key, one sorted key per item
//  csr_*     in         write enable, register index, write data
//
// A set of n = 2^L keys is loaded, sorted in L(L+1)/2 network stages of n/2
// compare-exchanges each, and emitted. The sort rate is one compare-exchange per cycle
// while a stage runs, set by the single read and write port of each of the two store banks.
// Reset clears control state only; the key store has no clearing pass.
// req_chan is ready only while a set is loading; rsp_chan stalls hold the shown key.
module bitonic_sorter_core (
   input  logic                              clock,
   input  logic                              reset,
   bs_req_if.sink                            req_chan,
   bs_rsp_if.source                          rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [bs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bs_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   typedef enum logic [1:0] {ST_LOAD, ST_SORT, ST_EMIT} core_state_type;

   typedef struct packed {
      logic                         valid;
      logic                         up;
      logic                         p_hi;
      logic [bs_pkg::BANK_AW-1:0]   a0;
      logic [bs_pkg::BANK_AW-1:0]   a1;
   } ce_pipe_type;

   core_state_type                state_ff, state_in;
   logic                          asc_ff, asc_in;
   logic [bs_pkg::SIZE_W-1:0]     size_ff, size_in;
   logic                          run_asc_ff, run_asc_in;
   logic [bs_pkg::STAGE_W-1:0]    run_l_ff, run_l_in;
   logic [bs_pkg::ADDR_W-1:0]     load_cnt_ff, load_cnt_in;
   logic [bs_pkg::ADDR_W-1:0]     emit_cnt_ff, emit_cnt_in;
   logic                          more_ff, more_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_bank_ff, rsp_bank_in;
   logic                          rsp_last_ff, rsp_last_in;
   ce_pipe_type                   ce_ff, ce_in;

   bs_pkg::seq_out_type           seq_out;
   logic                          seq_start;

   logic [bs_pkg::STAGE_W-1:0]    l_now;
   logic [bs_pkg::COUNT_W-1:0]    n_now;
   logic [bs_pkg::COUNT_W-1:0]    n_run;
   logic [bs_pkg::COUNT_W-1:0]    lc_next;
   logic                          req_accept;
   logic                          set_full;
   logic                          load_par;
   logic                          emit_par;
   logic                          emit_fetch;
   logic                          emit_last;
   logic                          rsp_accept;
   logic                          p_par;
   logic                          swap;
   logic [bs_pkg::KEY_W-1:0]      key_p;
   logic [bs_pkg::KEY_W-1:0]      key_q;

   logic                          b0_we, b1_we, b0_re, b1_re;
   logic [bs_pkg::BANK_AW-1:0]    b0_waddr, b1_waddr, b0_raddr, b1_raddr;
   logic [bs_pkg::KEY_W-1:0]      b0_wdata, b1_wdata, b0_rdata, b1_rdata;

   // Pair partners differ in one address bit, so the address parity puts them in
   // opposite banks and both can be read and written in the same cycle.
   bs_ram #(.WIDTH(bs_pkg::KEY_W), .DEPTH(bs_pkg::BANK_DEPTH)) u_bank0 (
      .clock   (clock),
      .wr_en   (b0_we),
      .wr_addr (b0_waddr),
      .wr_data (b0_wdata),
      .rd_en   (b0_re),
      .rd_addr (b0_raddr),
      .rd_data (b0_rdata)
   );

   bs_ram #(.WIDTH(bs_pkg::KEY_W), .DEPTH(bs_pkg::BANK_DEPTH)) u_bank1 (
      .clock   (clock),
      .wr_en   (b1_we),
      .wr_addr (b1_waddr),
      .wr_data (b1_wdata),
      .rd_en   (b1_re),
      .rd_addr (b1_raddr),
      .rd_data (b1_rdata)
   );

   bs_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (seq_start),
      .l       (run_l_ff),
      .asc     (run_asc_ff),
      .seq_out (seq_out)
   );

   assign req_chan.ready    = (state_ff == ST_LOAD);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.key_out  = rsp_bank_ff ? b1_rdata : b0_rdata;
   assign rsp_chan.last_key = rsp_last_ff;

   always_comb begin
      // Sizes below one act as one; sizes beyond the store act as the largest that fits.
      if (size_ff == '0) begin
         l_now = bs_pkg::STAGE_W'(1);
      end else if (size_ff > bs_pkg::SIZE_W'(bs_pkg::MAX_LOG2)) begin
         l_now = bs_pkg::STAGE_W'(bs_pkg::MAX_LOG2);
      end else begin
         l_now = bs_pkg::STAGE_W'(size_ff);
      end
      n_now      = bs_pkg::COUNT_W'(1) << l_now;
      n_run      = bs_pkg::COUNT_W'(1) << run_l_ff;
      lc_next    = {1'b0, load_cnt_ff} + 1'b1;
      req_accept = req_chan.valid && (state_ff == ST_LOAD);
      set_full   = req_accept && (lc_next >= n_now);
      seq_start  = set_full;
      rsp_accept = rsp_valid_ff && rsp_chan.ready;
      load_par   = ^load_cnt_ff;
      emit_par   = ^emit_cnt_ff;
      emit_fetch = (state_ff == ST_EMIT) && more_ff && (!rsp_valid_ff || rsp_chan.ready);
      emit_last  = ({1'b0, emit_cnt_ff} == n_run - 1'b1);
      p_par      = ^seq_out.p;

      key_p = ce_ff.p_hi ? b1_rdata : b0_rdata;
      key_q = ce_ff.p_hi ? b0_rdata : b1_rdata;
      swap  = (($signed(key_p) > $signed(key_q)) == ce_ff.up);
   end

   always_comb begin
      b0_we    = 1'b0;
      b1_we    = 1'b0;
      b0_waddr = bs_pkg::BANK_AW'(load_cnt_ff >> 1);
      b1_waddr = bs_pkg::BANK_AW'(load_cnt_ff >> 1);
      b0_wdata = req_chan.key_in;
      b1_wdata = req_chan.key_in;
      b0_re    = 1'b0;
      b1_re    = 1'b0;
      b0_raddr = bs_pkg::BANK_AW'(emit_cnt_ff >> 1);
      b1_raddr = bs_pkg::BANK_AW'(emit_cnt_ff >> 1);
      case (state_ff)
         ST_LOAD: begin
            b0_we = req_accept && !load_par;
            b1_we = req_accept && load_par;
         end
         ST_SORT: begin
            // Only a swap writes back; each bank takes the other bank's key.
            b0_we    = ce_ff.valid && swap;
            b1_we    = ce_ff.valid && swap;
            b0_waddr = ce_ff.a0;
            b1_waddr = ce_ff.a1;
            b0_wdata = b1_rdata;
            b1_wdata = b0_rdata;
            b0_re    = seq_out.ce_valid;
            b1_re    = seq_out.ce_valid;
            b0_raddr = p_par ? bs_pkg::BANK_AW'(seq_out.q >> 1)
                             : bs_pkg::BANK_AW'(seq_out.p >> 1);
            b1_raddr = p_par ? bs_pkg::BANK_AW'(seq_out.p >> 1)
                             : bs_pkg::BANK_AW'(seq_out.q >> 1);
         end
         ST_EMIT: begin
            b0_re = emit_fetch && !emit_par;
            b1_re = emit_fetch && emit_par;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      asc_in       = asc_ff;
      size_in      = size_ff;
      run_asc_in   = run_asc_ff;
      run_l_in     = run_l_ff;
      load_cnt_in  = load_cnt_ff;
      emit_cnt_in  = emit_cnt_ff;
      more_in      = more_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bank_in  = rsp_bank_ff;
      rsp_last_in  = rsp_last_ff;

      ce_in.valid = seq_out.ce_valid;
      ce_in.up    = seq_out.up;
      ce_in.p_hi  = p_par;
      ce_in.a0    = b0_raddr;
      ce_in.a1    = b1_raddr;

      if (csr_wr_en) begin
         case (csr_index)
            bs_pkg::REG_SORT_ASCENDING: asc_in  = csr_wr_data[0];
            bs_pkg::REG_SIZE_LOG2:      size_in = bs_pkg::SIZE_W'(csr_wr_data);
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (set_full) begin
               load_cnt_in = '0;
               run_l_in    = l_now;
               run_asc_in  = asc_ff;
               state_in    = ST_SORT;
            end else if (req_accept) begin
               load_cnt_in = load_cnt_ff + 1'b1;
            end
         end
         ST_SORT: begin
            if (seq_out.done) begin
               emit_cnt_in = '0;
               more_in     = 1'b1;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // The bank's read register is the output register: a read is issued
            // only when the shown item is taken or none is shown.
            if (emit_fetch) begin
               rsp_valid_in = 1'b1;
               rsp_bank_in  = emit_par;
               rsp_last_in  = emit_last;
               emit_cnt_in  = emit_cnt_ff + 1'b1;
               more_in      = !emit_last;
            end else if (rsp_accept) begin
               rsp_valid_in = 1'b0;
            end
            if (!more_ff && (!rsp_valid_ff || rsp_accept)) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         asc_ff       <= 1'b1;
         size_ff      <= bs_pkg::SIZE_LOG2_RESET;
         run_asc_ff   <= 1'b1;
         run_l_ff     <= '0;
         load_cnt_ff  <= '0;
         emit_cnt_ff  <= '0;
         more_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_bank_ff  <= 1'b0;
         rsp_last_ff  <= 1'b0;
         ce_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         asc_ff       <= asc_in;
         size_ff      <= size_in;
         run_asc_ff   <= run_asc_in;
         run_l_ff     <= run_l_in;
         load_cnt_ff  <= load_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         more_ff      <= more_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_bank_ff  <= rsp_bank_in;
         rsp_last_ff  <= rsp_last_in;
         ce_ff        <= ce_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pair_banks: assert property (@(posedge clock) disable iff (reset)
      seq_out.ce_valid |-> ((^seq_out.p) != (^seq_out.q)))
      else $error("compare-exchange pair falls into a single bank");

   a_ce_in_sort: assert property (@(posedge clock) disable iff (reset)
      ce_ff.valid |-> (state_ff == ST_SORT))
      else $error("compare-exchange write back outside the sort phase");

   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_EMIT))
      else $error("result item shown outside the emit phase");

   a_done_to_emit: assert property (@(posedge clock) disable iff (reset)
      seq_out.done |=> (state_ff == ST_EMIT) && (emit_cnt_ff == '0))
      else $error("network completion did not start emission");
`endif

endmodule
